[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define DDQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/ddq_pkg.sv]
package ddq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int CMD_W    = 3;
    localparam int KIND_W   = 3;
    localparam int STOCK_W  = 6;
    localparam int RANGE_W  = 4;
    localparam int AUX_W    = 16;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam int JOB_W      = KIND_W + STOCK_W + RANGE_W + AUX_W + TAG_W;
    localparam int S_TDATA_W  = ((JOB_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((JOB_W + CNT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PURGE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PENDING = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

    // last field in the low bits
    typedef struct packed {
        logic [TAG_W-1:0]   job_tag;
        logic [AUX_W-1:0]   job_aux;
        logic [RANGE_W-1:0] job_range;
        logic [STOCK_W-1:0] job_stock;
        logic [KIND_W-1:0]  job_kind;
    } job_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_PURGE,
        OP_SQUEEZE,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        job_t     job;
    } cell_ctrl_t;

    function automatic logic [CNT_W-1:0] occ_count(input logic [QUEUE_DEPTH-1:0] occ);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n = n + CNT_W'(occ[i]);
        end
        return n;
    endfunction

endpackage

[design/ddq_cell.sv]
module ddq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ddq_pkg::cell_ctrl_t ctrl,
    input  ddq_pkg::job_t      left_job,
    input  logic               left_occ,
    input  ddq_pkg::job_t      right_job,
    input  logic               right_occ,
    output ddq_pkg::job_t      job,
    output logic               occ,
    output logic               match
);
    import ddq_pkg::*;

    job_t job_reg, job_next;
    logic occ_reg, occ_next;
    logic match_reg, match_next;

    always_comb begin
        job_next = job_reg;
        occ_next = occ_reg;
        unique case (ctrl.op)
            OP_HOLD: begin
            end
            OP_APPEND: begin
                if (!occ_reg && left_occ) begin
                    job_next = ctrl.job;
                    occ_next = 1'b1;
                end
            end
            OP_INSERT: begin
                job_next = left_job;
                occ_next = left_occ;
            end
            OP_REMOVE: begin
                job_next = right_job;
                occ_next = right_occ;
            end
            OP_PURGE: begin
                if (occ_reg && job_reg.job_kind == ctrl.job.job_kind) begin
                    occ_next = 1'b0;
                end
            end
            OP_SQUEEZE: begin
                // fill a hole from the right; the mover leaves a hole behind
                if (!occ_reg && right_occ) begin
                    job_next = right_job;
                    occ_next = 1'b1;
                end else if (occ_reg && !left_occ) begin
                    occ_next = 1'b0;
                end
            end
            OP_CLEAR: begin
                occ_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign match_next = occ_reg
        && job_reg.job_kind  == ctrl.job.job_kind
        && job_reg.job_stock == ctrl.job.job_stock
        && job_reg.job_range == ctrl.job.job_range
        && job_reg.job_aux   == ctrl.job.job_aux;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign job   = job_reg;
    assign occ   = occ_reg;
    assign match = match_reg;

endmodule

[design/dedup_job_deque_unit.sv]
// Bounded job deque with duplicate suppression, held in a row of cells with the
// oldest job in the first cell. Every command transfer on the s_ side yields one
// result transfer on the m_ side. Push, pop, clear and unused codes pass these
// steps from accept to result: latch the command, let every cell compare its job
// against the pushed one, apply the command, load the result register once the
// previous result is taken. Purge adds a compaction pass between applying and
// loading, in which each job steps at most one cell toward the head per cycle. One
// command is in flight at a time; the next is taken once the result register is
// loaded, while that result may still wait for m_tready.
`include "assert_macros.svh"

module dedup_job_deque_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // job_kind, job_stock, job_range, job_aux, job_tag
    input  logic [ddq_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [ddq_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_kind, out_stock, out_range, out_aux, out_tag, pending
    output logic [ddq_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [ddq_pkg::STATUS_W-1:0]   m_tuser
);
    import ddq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MATCH  = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_PACK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    job_t                  job_reg, job_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    job_t                  out_job_reg, out_job_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    cell_ctrl_t            ctrl;
    job_t                  cell_job [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] match;
    logic                  gap;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        job_t left_job, right_job;
        logic left_occ, right_occ;
        if (i == 0) begin : g_first
            assign left_job = job_reg;
            assign left_occ = 1'b1;
        end else begin : g_mid
            assign left_job = cell_job[i-1];
            assign left_occ = occ[i-1];
        end
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_job = '0;
            assign right_occ = 1'b0;
        end else begin : g_inner
            assign right_job = cell_job[i+1];
            assign right_occ = occ[i+1];
        end
        ddq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .left_job  (left_job),
            .left_occ  (left_occ),
            .right_job (right_job),
            .right_occ (right_occ),
            .job       (cell_job[i]),
            .occ       (occ[i]),
            .match     (match[i])
        );
    end

    assign gap = |(occ[QUEUE_DEPTH-1:1] & ~occ[QUEUE_DEPTH-2:0]);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        job_next      = job_reg;
        status_next   = status_reg;
        out_job_next  = out_job_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ctrl.op       = OP_HOLD;
        ctrl.job      = job_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    job_next   = job_t'(s_tdata[JOB_W-1:0]);
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                status_next  = STAT_DONE;
                out_job_next = '0;
                state_next   = ST_FINISH;
                unique case (cmd_reg)
                    CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                        if (|match) begin
                            status_next = STAT_PENDING;
                        end else if (occ[QUEUE_DEPTH-1]) begin
                            status_next = STAT_FULL;
                        end else if (cmd_reg == CMD_PUSH_FRONT) begin
                            ctrl.op = OP_INSERT;
                        end else begin
                            ctrl.op = OP_APPEND;
                        end
                    end
                    CMD_POP: begin
                        if (!occ[0]) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            out_job_next = cell_job[0];
                            ctrl.op      = OP_REMOVE;
                        end
                    end
                    CMD_PURGE: begin
                        ctrl.op    = OP_PURGE;
                        state_next = ST_PACK;
                    end
                    CMD_CLEAR: begin
                        ctrl.op = OP_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            ST_PACK: begin
                if (gap) begin
                    ctrl.op = OP_SQUEEZE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({occ_count(occ), out_job_reg});
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        job_reg     <= job_next;
        status_reg  <= status_next;
        out_job_reg <= out_job_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DDQ_ASSERT(a_occ_packed, (state_reg != ST_PACK) |-> (((occ >> 1) & ~occ) == '0), "occupied cells not contiguous from head")
    `DDQ_ASSERT(a_full_count, (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[JOB_W +: CNT_W] == CNT_W'(QUEUE_DEPTH)), "full refusal while not full")
    `DDQ_ASSERT(a_empty_count, (m_tvalid && m_tuser == STAT_EMPTY) |-> (m_tdata[JOB_W +: CNT_W] == '0), "empty pop while jobs wait")
    `DDQ_ASSERT_NEXT(a_clear, (state_reg == ST_EXEC && cmd_reg == CMD_CLEAR), (occ == '0), "clear left occupied cells")

endmodule
